// File: hw/rtl/assert_macros.svh
// Assertion macros of the loader RTL, used by the parser.
// Active in simulation; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ORL_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define ORL_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ORL_ASSERT(label, clk, rst, prop)
`define ORL_NEVER(label, clk, rst, cond)
`endif
`endif

// File: hw/rtl/orl_pkg.sv
// Shared types, constants and the hex digit decoder of the object record loader.
// No dependencies.
package orl_pkg;

  localparam int ADDR_DIGITS_DEFAULT = 6;
  localparam int ADDR_W = 24;
  localparam int BYTE_W = 8;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_START = 1'b1;

  typedef struct packed {
    logic                valid;
    logic                kind;
    logic [ADDR_W-1:0]   address;
    logic [BYTE_W-1:0]   data_byte;
  } result_t;

  // Decode one ASCII hex digit; anything else reads as zero.
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] nib;
    nib = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      nib = 4'(c - 8'h30);
    end else if (c inside {[8'h41:8'h46]}) begin
      nib = 4'(c - 8'h37);
    end else if (c inside {[8'h61:8'h66]}) begin
      nib = 4'(c - 8'h57);
    end
    return nib;
  endfunction

endpackage

// File: hw/rtl/orl_in_stage.sv
// Input register of the object record loader: holds one character for the parser.
// Depends on nothing but the port handshake.
module orl_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_in,
  input  logic       advance,
  output logic       char_valid,
  output logic [7:0] char_q
);

  // Stall only while a held character cannot move on.
  assign in_stall = char_valid & ~advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (~char_valid | advance) begin
      char_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if ((~char_valid | advance) & in_valid) begin
      char_q <= char_in;
    end
  end

endmodule

// File: hw/rtl/orl_parser.sv
// Record parser of the object record loader: one state update per character.
// Depends on orl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module orl_parser #(
  parameter int ADDR_DIGITS = orl_pkg::ADDR_DIGITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [7:0]       char_q,
  output orl_pkg::result_t res
);

  localparam logic [2:0] LAST_DIGIT = 3'(ADDR_DIGITS - 1);

  localparam logic [7:0] CH_H  = 8'h48;
  localparam logic [7:0] CH_T  = 8'h54;
  localparam logic [7:0] CH_E  = 8'h45;
  localparam logic [7:0] CH_NL = 8'h0A;

  typedef enum logic [5:0] {
    M_IDLE   = 6'b000001,
    M_SKIP   = 6'b000010,
    M_TADDR  = 6'b000100,
    M_TCOUNT = 6'b001000,
    M_TDATA  = 6'b010000,
    M_EADDR  = 6'b100000
  } mode_t;

  mode_t       mode, mode_next;
  logic [2:0]  digit_count, digit_count_next;
  logic [23:0] load_address, load_address_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [3:0]  high_nibble, high_nibble_next;

  logic [3:0]  nib;
  logic [23:0] shifted_addr;
  logic [7:0]  shifted_count;
  logic [7:0]  bytes_dec;

  assign nib           = orl_pkg::hex_nibble(char_q);
  assign shifted_addr  = {load_address[19:0], nib};
  assign shifted_count = {bytes_left[3:0], nib};
  assign bytes_dec     = bytes_left - 8'd1;

  always_comb begin
    mode_next         = mode;
    digit_count_next  = digit_count;
    load_address_next = load_address;
    bytes_left_next   = bytes_left;
    high_nibble_next  = high_nibble;
    res               = '0;
    case (mode)
      M_IDLE: begin
        if (char_q == CH_H) begin
          mode_next = M_SKIP;
        end else if (char_q == CH_T || char_q == CH_E) begin
          mode_next         = (char_q == CH_T) ? M_TADDR : M_EADDR;
          digit_count_next  = 3'd0;
          load_address_next = '0;
        end
      end
      M_SKIP: begin
        if (char_q == CH_NL) mode_next = M_IDLE;
      end
      M_TADDR: begin
        load_address_next = shifted_addr;
        if (digit_count >= LAST_DIGIT) begin
          mode_next        = M_TCOUNT;
          digit_count_next = 3'd0;
          bytes_left_next  = '0;
        end else begin
          digit_count_next = digit_count + 3'd1;
        end
      end
      M_TCOUNT: begin
        bytes_left_next = shifted_count;
        if (digit_count != 3'd0) begin
          digit_count_next = 3'd0;
          mode_next        = (shifted_count == 8'd0) ? M_SKIP : M_TDATA;
        end else begin
          digit_count_next = 3'd1;
        end
      end
      M_TDATA: begin
        if (digit_count == 3'd0) begin
          high_nibble_next = nib;
          digit_count_next = 3'd1;
        end else begin
          digit_count_next  = 3'd0;
          res.valid         = 1'b1;
          res.kind          = orl_pkg::KIND_WRITE;
          res.address       = load_address;
          res.data_byte     = {high_nibble, nib};
          load_address_next = load_address + 24'd1;
          bytes_left_next   = bytes_dec;
          if (bytes_dec == 8'd0) mode_next = M_SKIP;
        end
      end
      M_EADDR: begin
        load_address_next = shifted_addr;
        if (digit_count >= LAST_DIGIT) begin
          digit_count_next = 3'd0;
          mode_next        = M_SKIP;
          res.valid        = 1'b1;
          res.kind         = orl_pkg::KIND_START;
          res.address      = shifted_addr;
        end else begin
          digit_count_next = digit_count + 3'd1;
        end
      end
      default: begin
        mode_next = M_IDLE;
      end
    endcase
    // Hold everything when no character is taken this cycle.
    if (!fire) begin
      mode_next         = mode;
      digit_count_next  = digit_count;
      load_address_next = load_address;
      bytes_left_next   = bytes_left;
      high_nibble_next  = high_nibble;
      res.valid         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      digit_count  <= 3'd0;
      load_address <= '0;
      bytes_left   <= '0;
      high_nibble  <= '0;
    end else begin
      mode         <= mode_next;
      digit_count  <= digit_count_next;
      load_address <= load_address_next;
      bytes_left   <= bytes_left_next;
      high_nibble  <= high_nibble_next;
    end
  end

  `ORL_NEVER(a_res_mode, clk, rst, res.valid && mode != M_TDATA && mode != M_EADDR)
  `ORL_NEVER(a_start_kind, clk, rst, res.valid && res.kind == orl_pkg::KIND_START && mode != M_EADDR)
  `ORL_NEVER(a_data_empty, clk, rst, mode == M_TDATA && bytes_left == 8'd0)
  `ORL_NEVER(a_byte_digits, clk, rst, (mode == M_TDATA || mode == M_TCOUNT) && digit_count > 3'd1)
  `ORL_ASSERT(a_hold, clk, rst, !fire |=> $stable(mode) && $stable(load_address))

endmodule

// File: hw/rtl/orl_out_stage.sv
// Result register of the object record loader: holds one transfer for the consumer.
// Depends on orl_pkg.
module orl_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  orl_pkg::result_t res,
  output logic             advance,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             kind,
  output logic [23:0]      address,
  output logic [7:0]       data_byte
);

  // Room for a new result when empty or when the held one leaves now.
  assign advance = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance & res.valid) begin
      kind      <= res.kind;
      address   <= res.address;
      data_byte <= res.data_byte;
    end
  end

endmodule

// File: hw/rtl/object_record_loader_unit.sv
// Top level of the object record loader: input register, parser, result register.
// Depends on orl_pkg, orl_in_stage, orl_parser and orl_out_stage.
//
// Takes an object-program text one character per transfer and returns memory
// byte writes (kind 0) from 'T' records and the start address (kind 1) from an
// 'E' record. One character is accepted every cycle while the result side does
// not stall. A record's last character is held in the input register, the parser
// decodes it, and its result is loaded into the result register, from which the
// result is transferred. The rate is set by the parser's record state, which is
// updated once per character. A stall on the result side holds the result
// register and the parser; the input register still takes one character if it
// is empty, and after that the input stalls until the held result leaves.
module object_record_loader_unit #(
  parameter int ADDR_DIGITS = orl_pkg::ADDR_DIGITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [23:0] address,
  output logic [7:0]  data_byte
);

  logic             advance;
  logic             char_valid;
  logic [7:0]       char_q;
  orl_pkg::result_t res;

  orl_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_in    (char_in),
    .advance    (advance),
    .char_valid (char_valid),
    .char_q     (char_q)
  );

  orl_parser #(
    .ADDR_DIGITS (ADDR_DIGITS)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .fire   (char_valid & advance),
    .char_q (char_q),
    .res    (res)
  );

  orl_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .address   (address),
    .data_byte (data_byte)
  );

endmodule

// File: dv/object_record_loader_unit_test.sv
`timescale 1ns / 100ps
// Testbench for object_record_loader_unit: drives object-program text, predicts
// memory writes and start addresses, and checks them in order. Depends on orl_pkg.
module object_record_loader_unit_test;

  localparam int ADDR_DIGITS = orl_pkg::ADDR_DIGITS_DEFAULT;
  localparam int ITEMS       = 1950;
  localparam int QUIET_TAIL  = 200;
  localparam int SETTLE      = 10;
  localparam int IDLE_LIMIT  = 2000;

  localparam logic [7:0] CH_HEADER  = 8'h48;  // 'H'
  localparam logic [7:0] CH_TEXT    = 8'h54;  // 'T'
  localparam logic [7:0] CH_END     = 8'h45;  // 'E'
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  class load_tracker;
    typedef enum logic [2:0] {
      PM_IDLE, PM_SKIP, PM_TADDR, PM_TCOUNT, PM_TDATA, PM_EADDR
    } parse_mode_t;

    typedef struct packed {
      logic        kind;
      logic [23:0] address;
      logic [7:0]  data_byte;
    } load_result_t;

    parse_mode_t  mode;
    logic [2:0]   digits;
    logic [23:0]  load_addr;
    logic [7:0]   bytes_left;
    logic [3:0]   high_nib;
    logic [23:0]  start_addr;
    load_result_t due_results[$];
    int           errors;

    function new();
      mode       = PM_IDLE;
      digits     = '0;
      load_addr  = '0;
      bytes_left = '0;
      high_nib   = '0;
      start_addr = 24'h008000;
      errors     = 0;
    endfunction

    function logic [3:0] digit_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
      if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
      return 4'd0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Advance the parser by one accepted character.
    function void take_char(logic [7:0] c);
      logic [3:0]   nib;
      load_result_t r;
      nib = digit_value(c);
      case (mode)
        PM_IDLE: begin
          if (c == CH_HEADER) begin
            mode = PM_SKIP;
          end else if (c == CH_TEXT || c == CH_END) begin
            mode      = (c == CH_TEXT) ? PM_TADDR : PM_EADDR;
            digits    = '0;
            load_addr = '0;
          end
        end
        PM_SKIP: begin
          if (c == CH_NEWLINE) mode = PM_IDLE;
        end
        PM_TADDR: begin
          load_addr = {load_addr[19:0], nib};
          if (digits >= ADDR_DIGITS - 1) begin
            mode       = PM_TCOUNT;
            digits     = '0;
            bytes_left = '0;
          end else begin
            digits = digits + 3'd1;
          end
        end
        PM_TCOUNT: begin
          bytes_left = {bytes_left[3:0], nib};
          if (digits >= 1) begin
            digits = '0;
            mode   = (bytes_left == 0) ? PM_SKIP : PM_TDATA;
          end else begin
            digits = 3'd1;
          end
        end
        PM_TDATA: begin
          if (digits == 0) begin
            high_nib = nib;
            digits   = 3'd1;
          end else begin
            digits      = '0;
            r.kind      = orl_pkg::KIND_WRITE;
            r.address   = load_addr;
            r.data_byte = {high_nib, nib};
            due_results.push_back(r);
            load_addr  = load_addr + 24'd1;
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 0) mode = PM_SKIP;
          end
        end
        PM_EADDR: begin
          load_addr = {load_addr[19:0], nib};
          if (digits >= ADDR_DIGITS - 1) begin
            digits      = '0;
            start_addr  = load_addr;
            mode        = PM_SKIP;
            r.kind      = orl_pkg::KIND_START;
            r.address   = start_addr;
            r.data_byte = 8'h00;
            due_results.push_back(r);
          end else begin
            digits = digits + 3'd1;
          end
        end
        default: mode = PM_IDLE;
      endcase
    endfunction

    function void check_result(logic k, logic [23:0] a, logic [7:0] d);
      load_result_t r;
      if (due_results.size() == 0) begin
        $error("unexpected result: kind %0d address %h data_byte %h", k, a, d);
        errors++;
        return;
      end
      r = due_results.pop_front();
      if (k !== r.kind) begin
        $error("kind: expected %0d, got %0d", r.kind, k);
        errors++;
      end
      if (a !== r.address) begin
        $error("address: expected %h, got %h", r.address, a);
        errors++;
      end
      if (d !== r.data_byte) begin
        $error("data_byte: expected %h, got %h", r.data_byte, d);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_in = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic [23:0] address;
  logic [7:0]  data_byte;

  load_tracker tracker = new();
  int chars_sent;
  int idle_cycles;
  int stall_run;
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  bit calm    = 1'b0;

  object_record_loader_unit #(.ADDR_DIGITS(ADDR_DIGITS)) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_in   (char_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .address   (address),
    .data_byte (data_byte)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Observe both channels at the edge; values seen here are the pre-edge ones.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (in_valid && !in_stall) begin
        tracker.take_char(char_in);
        idle_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        tracker.check_result(kind, address, data_byte);
        idle_cycles = 0;
      end
    end
  end

  // Result side stalls in bursts of random length.
  always @(posedge clk) begin
    if (rst || calm || !rx_gaps) begin
      stall_run = 0;
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_run = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    @(negedge rst);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
    if (n < 10) return 8'("0" + n);
    return lower ? 8'("a" + n - 10) : 8'("A" + n - 10);
  endfunction

  // Hold the character until the transfer happens; optionally idle first.
  task automatic send_char(input logic [7:0] c);
    if (tx_gaps && !calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Mostly proper hex digits in either case; now and then any byte at all.
  task automatic send_hex(input logic [31:0] value, input int ndig);
    logic [3:0] n;
    for (int i = ndig - 1; i >= 0; i--) begin
      n = value[4*i +: 4];
      if ($urandom_range(0, 39) == 0) send_char(8'($urandom_range(0, 255)));
      else send_char(hex_char(n, 1'($urandom_range(0, 1))));
    end
  endtask

  task automatic send_line_tail();
    repeat ($urandom_range(0, 3)) send_char(8'($urandom_range(32, 126)));
    if ($urandom_range(0, 19) != 0) send_char(CH_NEWLINE);
  endtask

  task automatic send_text_record(input logic [23:0] addr, input logic [7:0] count);
    send_char(CH_TEXT);
    send_hex(32'(addr), ADDR_DIGITS);
    send_hex(32'(count), 2);
    for (int i = 0; i < count; i++) send_hex($urandom_range(0, 255), 2);
    send_line_tail();
  endtask

  task automatic send_end_record(input logic [23:0] addr);
    send_char(CH_END);
    send_hex(32'(addr), ADDR_DIGITS);
    send_line_tail();
  endtask

  task automatic send_header_record();
    send_char(CH_HEADER);
    repeat ($urandom_range(0, 12)) send_char(8'($urandom_range(0, 255)));
    send_char(CH_NEWLINE);
  endtask

  // Hold the input until every predicted result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int          pick;
    logic [23:0] addr;
    logic [7:0]  count;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Header skipped, odd bytes outside any record dropped.
    send_char(CH_HEADER);
    send_char(8'hFF);
    send_char(CH_NEWLINE);
    send_char(8'h00);
    send_char(8'hFF);
    // Mixed-case address at the top wraps to zero; newline and 'G' as digits.
    send_text("TFfFFfF02a5\nG\n");
    // Zero byte count.
    send_text("T00000000\n");
    // Start address with a NUL in the last digit position.
    send_text("E7fC00");
    send_char(8'h00);
    send_char(CH_NEWLINE);
    drain();

    while (chars_sent < ITEMS) begin
      calm    = (chars_sent >= ITEMS - QUIET_TAIL);
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      pick    = $urandom_range(0, 99);
      addr    = ($urandom_range(0, 7) == 0) ? 24'hFFFFFF - 24'($urandom_range(0, 3))
                                             : 24'($urandom);
      if (pick < 55) begin
        count = ($urandom_range(0, 59) == 0) ? 8'($urandom_range(16, 255))
                                             : 8'($urandom_range(0, 8));
        send_text_record(addr, count);
      end else if (pick < 67) begin
        send_end_record(addr);
      end else if (pick < 77) begin
        send_header_record();
      end else if (pick < 87) begin
        repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
      end else begin
        // Record usually cut short, so the next record's letter can land in a digit slot.
        send_char(($urandom_range(0, 1) == 0) ? CH_TEXT : CH_END);
        send_hex($urandom, $urandom_range(1, 7));
      end
      if ($urandom_range(0, 149) == 0) drain();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/orl_pkg.sv
hw/rtl/orl_in_stage.sv
hw/rtl/orl_parser.sv
hw/rtl/orl_out_stage.sv
hw/rtl/object_record_loader_unit.sv
dv/object_record_loader_unit_test.sv
